FILE: hw/rtl/esmf_pkg.sv
// shared types, constants and helpers for the ecg segment mask fiducial post block
package esmf_pkg;

	localparam int WINDOW_LEN  = 512;
	localparam int NUM_CLASSES = 4;
	localparam int POS_W       = $clog2(WINDOW_LEN);
	localparam int CNT_W       = POS_W + 1;
	localparam int SUM_W       = 26;
	localparam int PROD_W      = 17 + CNT_W + 1;
	localparam int IN_DATA_W   = 96;
	localparam int OUT_DATA_W  = 8;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int RUN_MIN     = 2;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_PAD_LEN   = 3'd0,
		REG_SEG_THR   = 3'd1,
		REG_QOS_GOOD  = 3'd2,
		REG_QOS_FAIR  = 3'd3,
		REG_QOS_POOR  = 3'd4,
		REG_BAD_MEAN  = 3'd5
	} reg_idx_t;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_READ = 1'b1
	} req_t;

	typedef struct packed {
		logic [1:0]  cls;
		logic [1:0]  qual;
		logic [15:0] mag;
	} entry_t;

	typedef struct packed {
		logic        we;
		logic [POS_W-1:0] waddr;
		entry_t      wdata;
		logic        re;
		logic [POS_W-1:0] raddr;
		logic        fwe;
		logic [POS_W-1:0] fwaddr;
		logic [1:0]  fwdata;
		logic        fre;
		logic [POS_W-1:0] fraddr;
	} mem_req_t;

	typedef struct packed {
		logic [1:0]         cls;
		logic [1:0]         qual;
		logic signed [15:0] best;
		logic [15:0]        mag;
	} grade_t;

	function automatic logic is_pad(input logic [POS_W-1:0] p, input logic [7:0] pad);
		logic [CNT_W:0] s;
		s = {2'b00, p} + {{(CNT_W+1-8){1'b0}}, pad};
		return ({1'b0, p} < {{(CNT_W-8){1'b0}}, pad}) || (s >= (CNT_W+1)'(WINDOW_LEN));
	endfunction

endpackage

FILE: hw/rtl/ecg_segment_mask_fiducial_post_top.sv
// ecg segment mask fiducial post-processor top level
// a load word is taken while the block is idle; a read word holds off the input until its result
// is registered after the memory read, later while an earlier result waits on m_tready
// window_end starts a finish pass: a mean test (ST_MUL, ST_CMP), then a read and a write-back step
// per position through the result memory, plus a mark step where a fiducial is marked
// no word is accepted during the finish pass; configuration writes are taken at any time
// arst_n clears control state and loads register defaults; memories are not cleared
module ecg_segment_mask_fiducial_post_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// sample, score_zero, score_one, score_two, score_three, read_pos
	input  logic [esmf_pkg::IN_DATA_W-1:0]      s_tdata,
	// req_type
	input  logic                                s_tuser,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// seg_class, quality, fiducial_class, window_ready
	output logic [esmf_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  logic [esmf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [esmf_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import esmf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RDWAIT, ST_MUL, ST_CMP, ST_SCAN_RD, ST_SCAN_PROC, ST_MARK
	} state_t;

	state_t state_q;

	logic [7:0]         pad_q;
	logic signed [15:0] thr_q, good_q, fair_q, poor_q, bml_q;

	logic [CNT_W-1:0]        load_pos_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    computed_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                    bad_q;
	logic [POS_W-1:0]        idx_q, start_q, pp_q, rd_pos_q;
	logic [1:0]              prev_q, mark_cls_q;
	logic                    active_q, rd_comp_q;
	logic [15:0]             peak_q;
	logic                    m_tvalid_q;
	logic [OUT_DATA_W-1:0]   m_tdata_q;

	logic               acc;
	logic               is_load, is_read;
	logic [POS_W-1:0]   read_pos;
	grade_t             grade;
	mem_req_t           mreq;
	entry_t             rdata;
	logic [1:0]         frdata;
	logic               out_free;
	logic [CNT_W-1:0]   count;
	logic               cnt_pos;
	logic               load_in;
	logic               load_pad;

	logic [1:0]         cur_cls, cur_qual;
	logic               sc_mark;
	logic [POS_W-1:0]   run_len;

	assign read_pos = s_tdata[88:80];
	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign is_load  = acc && (s_tuser == REQ_LOAD);
	assign is_read  = acc && (s_tuser == REQ_READ);
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign load_in  = (load_pos_q < CNT_W'(WINDOW_LEN));
	assign load_pad = is_pad(load_pos_q[POS_W-1:0], pad_q);

	assign cnt_pos = ({1'b0, pad_q, 1'b0} < (CNT_W+1)'(WINDOW_LEN));
	assign count   = cnt_pos ? CNT_W'(CNT_W'(WINDOW_LEN) - {pad_q, 1'b0}) : '0;

	esmf_grade u_grade (
		.sample         (s_tdata[15:0]),
		.score_zero     (s_tdata[31:16]),
		.score_one      (s_tdata[47:32]),
		.score_two      (s_tdata[63:48]),
		.score_three    (s_tdata[79:64]),
		.seg_threshold  (thr_q),
		.qos_good_level (good_q),
		.qos_fair_level (fair_q),
		.qos_poor_level (poor_q),
		.grade          (grade)
	);

	esmf_mem u_mem (
		.clk    (clk),
		.req    (mreq),
		.rdata  (rdata),
		.frdata (frdata)
	);

	// scan step on the word just read back
	always_comb begin
		cur_cls  = (bad_q || is_pad(idx_q, pad_q)) ? 2'd0 : rdata.cls;
		cur_qual = (bad_q || is_pad(idx_q, pad_q)) ? 2'd0 : rdata.qual;
		run_len  = idx_q - start_q;
		sc_mark  = (idx_q != '0) && (cur_cls == 2'd0) && (prev_q != 2'd0) && active_q
			&& (run_len > POS_W'(RUN_MIN));
	end

	always_comb begin
		mreq = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (is_load && load_in) begin
					mreq.we     = 1'b1;
					mreq.waddr  = load_pos_q[POS_W-1:0];
					mreq.wdata  = '{cls: load_pad ? 2'd0 : grade.cls,
						qual: load_pad ? 2'd0 : grade.qual, mag: grade.mag};
					mreq.fwe    = 1'b1;
					mreq.fwaddr = load_pos_q[POS_W-1:0];
				end
				if (is_read) begin
					mreq.re     = 1'b1;
					mreq.raddr  = read_pos;
					mreq.fre    = 1'b1;
					mreq.fraddr = read_pos;
				end
			end
			ST_SCAN_RD: begin
				mreq.re    = 1'b1;
				mreq.raddr = idx_q;
			end
			ST_SCAN_PROC: begin
				mreq.we     = 1'b1;
				mreq.waddr  = idx_q;
				mreq.wdata  = '{cls: cur_cls, qual: cur_qual, mag: rdata.mag};
				mreq.fwe    = 1'b1;
				mreq.fwaddr = idx_q;
			end
			ST_MARK: begin
				mreq.fwe    = 1'b1;
				mreq.fwaddr = pp_q;
				mreq.fwdata = mark_cls_q;
			end
			default: mreq = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q  <= '0;
			thr_q  <= '0;
			good_q <= 16'sd13107;
			fair_q <= 16'sd9830;
			poor_q <= 16'sd6554;
			bml_q  <= 16'sd8192;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_PAD_LEN:  pad_q  <= cfg_data[7:0];
				REG_SEG_THR:  thr_q  <= cfg_data;
				REG_QOS_GOOD: good_q <= cfg_data;
				REG_QOS_FAIR: fair_q <= cfg_data;
				REG_QOS_POOR: poor_q <= cfg_data;
				REG_BAD_MEAN: bml_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			load_pos_q <= '0;
			sum_q      <= '0;
			computed_q <= 1'b0;
			bad_q      <= 1'b0;
			idx_q      <= '0;
			active_q   <= 1'b0;
			prev_q     <= '0;
			rd_comp_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_RDWAIT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (is_load) begin
						computed_q <= 1'b0;
						if (load_in) begin
							load_pos_q <= load_pos_q + 1'b1;
							if (!load_pad) sum_q <= sum_q + SUM_W'(grade.best);
						end
						if (s_tlast) state_q <= ST_MUL;
					end
					if (is_read) begin
						rd_pos_q  <= read_pos;
						rd_comp_q <= computed_q;
						state_q   <= ST_RDWAIT;
					end
				end
				ST_RDWAIT: begin
					if (out_free) begin
						if (rd_comp_q && !is_pad(rd_pos_q, pad_q)) begin
							m_tdata_q <= {1'b0, 1'b1, frdata, rdata.qual, rdata.cls};
						end else begin
							m_tdata_q <= {1'b0, rd_comp_q, 6'd0};
						end
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					prod_q  <= bml_q * $signed({1'b0, count});
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					bad_q   <= cnt_pos && (PROD_W'(sum_q) < prod_q);
					idx_q   <= '0;
					state_q <= ST_SCAN_RD;
				end
				ST_SCAN_RD: state_q <= ST_SCAN_PROC;
				ST_SCAN_PROC: begin
					prev_q <= cur_cls;
					if (idx_q == '0) begin
						active_q <= 1'b1;
						start_q  <= '0;
						peak_q   <= rdata.mag;
						pp_q     <= '0;
					end else if (cur_cls != 2'd0 && prev_q == 2'd0) begin
						active_q <= 1'b1;
						start_q  <= idx_q;
						peak_q   <= rdata.mag;
						pp_q     <= idx_q;
					end else if (cur_cls == 2'd0 && prev_q != 2'd0) begin
						active_q <= 1'b0;
					end else if (active_q && rdata.mag > peak_q) begin
						peak_q <= rdata.mag;
						pp_q   <= idx_q;
					end
					mark_cls_q <= prev_q;
					if (sc_mark) begin
						state_q <= ST_MARK;
					end else if (idx_q == POS_W'(WINDOW_LEN - 1)) begin
						load_pos_q <= '0;
						sum_q      <= '0;
						computed_q <= 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_MARK: begin
					if (idx_q == POS_W'(WINDOW_LEN - 1)) begin
						load_pos_q <= '0;
						sum_q      <= '0;
						computed_q <= 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		is_load |=> !computed_q)
		else $error("load did not clear computed flag");

	a_mark_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK) |-> ($past(state_q) == ST_SCAN_PROC))
		else $error("mark step without scan step");

	a_done_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(computed_q) |-> (load_pos_q == '0 && sum_q == '0 && state_q == ST_IDLE))
		else $error("finish pass left load state");

	a_mark_before: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK) |-> (pp_q < idx_q))
		else $error("fiducial marked at or past scan index");

endmodule

FILE: hw/rtl/esmf_grade.sv
// argmax, threshold and quality grading of one load word
module esmf_grade (
	input  logic signed [15:0] sample,
	input  logic signed [15:0] score_zero,
	input  logic signed [15:0] score_one,
	input  logic signed [15:0] score_two,
	input  logic signed [15:0] score_three,
	input  logic signed [15:0] seg_threshold,
	input  logic signed [15:0] qos_good_level,
	input  logic signed [15:0] qos_fair_level,
	input  logic signed [15:0] qos_poor_level,
	output esmf_pkg::grade_t   grade
);
	import esmf_pkg::*;

	logic signed [15:0] scores [4];
	logic signed [15:0] best;
	logic [1:0]         best_idx;

	assign scores[0] = score_zero;
	assign scores[1] = score_one;
	assign scores[2] = score_two;
	assign scores[3] = score_three;

	always_comb begin
		best     = scores[0];
		best_idx = 2'd0;
		for (int j = 1; j < NUM_CLASSES; j++) begin
			if (scores[j] > best) begin
				best     = scores[j];
				best_idx = 2'(j);
			end
		end
	end

	always_comb begin
		grade.best = best;
		grade.cls  = (best >= seg_threshold) ? best_idx : 2'd0;
		if (best > qos_good_level)      grade.qual = 2'd3;
		else if (best > qos_fair_level) grade.qual = 2'd2;
		else if (best > qos_poor_level) grade.qual = 2'd1;
		else                            grade.qual = 2'd0;
		grade.mag = sample[15] ? 16'(~sample + 16'sd1) : 16'(sample);
	end

endmodule

FILE: hw/rtl/esmf_mem.sv
// per-position result memories: class, quality, magnitude and fiducial
module esmf_mem (
	input  logic                clk,
	input  esmf_pkg::mem_req_t  req,
	output esmf_pkg::entry_t    rdata,
	output logic [1:0]          frdata
);
	import esmf_pkg::*;

	entry_t     main_mem [WINDOW_LEN];
	logic [1:0] fid_mem  [WINDOW_LEN];

	always_ff @(posedge clk) begin
		if (req.we) main_mem[req.waddr] <= req.wdata;
		if (req.re) rdata <= main_mem[req.raddr];
	end

	always_ff @(posedge clk) begin
		if (req.fwe) fid_mem[req.fwaddr] <= req.fwdata;
		if (req.fre) frdata <= fid_mem[req.fraddr];
	end

endmodule

FILE: bench/ecg_segment_mask_fiducial_post_top_tb.sv
// testbench for the ecg segment mask fiducial post block: directed table, then random windows
`timescale 1ns / 100ps

module ecg_segment_mask_fiducial_post_top_tb;
	import esmf_pkg::*;

	localparam int SETTLE_CYCLES = 1700;
	localparam int IDLE_LIMIT    = 8000;

	typedef struct {
		req_t        req;
		logic [15:0] smp;
		logic [15:0] sc [4];
		logic        wend;
		logic [8:0]  rpos;
		logic        typed;
		logic [7:0]  want;
	} word_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic s_tuser;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor state
	logic [1:0]  cls_mem [WINDOW_LEN];
	logic [1:0]  qual_mem [WINDOW_LEN];
	logic [1:0]  fid_mem [WINDOW_LEN];
	logic [15:0] mag_mem [WINDOW_LEN];
	int          load_pos;
	longint      best_sum;
	logic        win_done;
	logic [7:0]  pad_r;
	logic signed [15:0] thr_r, good_r, fair_r, poor_r, bad_r;

	logic [7:0] pending_q [$];
	int  mismatches;
	int  idle_cycles;
	int  stall_left;
	bit  in_run;

	ecg_segment_mask_fiducial_post_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic bit pad_pos(int p);
		return p < pad_r || p + pad_r >= WINDOW_LEN;
	endfunction

	function automatic void close_window();
		int     cnt, i, start, peak_pos;
		bit     bad, active;
		logic [1:0] prev, cur;
		logic [15:0] peak;
		cnt = (2 * pad_r < WINDOW_LEN) ? WINDOW_LEN - 2 * pad_r : 0;
		bad = cnt > 0 && best_sum < longint'(bad_r) * cnt;
		for (i = 0; i < WINDOW_LEN; i++) begin
			if (bad || pad_pos(i)) begin
				cls_mem[i] = 0;
				qual_mem[i] = 0;
			end
			fid_mem[i] = 0;
		end
		prev = cls_mem[0];
		active = 1;
		start = 0;
		peak_pos = 0;
		peak = mag_mem[0];
		for (i = 1; i < WINDOW_LEN; i++) begin
			cur = cls_mem[i];
			if (cur != 0 && prev == 0) begin
				active = 1;
				start = i;
				peak = mag_mem[i];
				peak_pos = i;
			end else if (cur == 0 && prev != 0) begin
				if (active && i - start > RUN_MIN)
					fid_mem[peak_pos] = prev;
				active = 0;
			end else if (active && mag_mem[i] > peak) begin
				peak = mag_mem[i];
				peak_pos = i;
			end
			prev = cur;
		end
		load_pos = 0;
		best_sum = 0;
		win_done = 1;
	endfunction

	// returns 1 and the packed result word when the word yields a result
	function automatic bit grade_word(word_t w, output logic [7:0] res);
		int best, j, smp, q, c;
		res = '0;
		if (w.req == REQ_LOAD) begin
			win_done = 0;
			if (load_pos < WINDOW_LEN) begin
				best = int'($signed(w.sc[0]));
				c = 0;
				for (j = 1; j < NUM_CLASSES; j++)
					if (int'($signed(w.sc[j])) > best) begin
						best = int'($signed(w.sc[j]));
						c = j;
					end
				q = best > good_r ? 3 : best > fair_r ? 2 : best > poor_r ? 1 : 0;
				if (best < thr_r)
					c = 0;
				smp = int'($signed(w.smp));
				mag_mem[load_pos] = 16'(smp < 0 ? -smp : smp);
				fid_mem[load_pos] = 0;
				if (pad_pos(load_pos)) begin
					cls_mem[load_pos] = 0;
					qual_mem[load_pos] = 0;
				end else begin
					cls_mem[load_pos] = 2'(c);
					qual_mem[load_pos] = 2'(q);
					best_sum += best;
				end
				load_pos++;
			end
			if (w.wend)
				close_window();
			return 0;
		end
		res[6] = win_done;
		if (win_done && !pad_pos(w.rpos))
			res[5:0] = {fid_mem[w.rpos], qual_mem[w.rpos], cls_mem[w.rpos]};
		return 1;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic word_t load_word(bit wend);
		word_t w;
		int k, j;
		w.req = REQ_LOAD;
		w.smp = 16'($urandom);
		w.wend = wend;
		w.rpos = 9'($urandom);
		w.typed = 0;
		w.want = 0;
		if ($urandom_range(5) == 0)
			in_run = !in_run;
		if ($urandom_range(9) == 0) begin
			for (j = 0; j < 4; j++)
				w.sc[j] = 16'($urandom);
		end else begin
			k = in_run ? $urandom_range(3, 1) : 0;
			for (j = 0; j < 4; j++)
				w.sc[j] = 16'($signed($urandom_range(40767)) - 32768);
			w.sc[k] = 16'($urandom_range(32767, 8000));
		end
		return w;
	endfunction

	function automatic word_t read_word(logic [8:0] p);
		word_t w;
		w = load_word(1'($urandom));
		w.req = REQ_READ;
		w.rpos = p;
		return w;
	endfunction

	task automatic send(word_t w);
		logic [7:0] res;
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= w.req;
		s_tlast <= w.wend;
		s_tdata <= {7'd0, w.rpos, w.sc[3], w.sc[2], w.sc[1], w.sc[0], w.smp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (grade_word(w, res))
			pending_q.push_back(w.typed ? w.want : res);
	endtask

	// the caller drops cfg_we after its last write
	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_PAD_LEN:  pad_r = val[7:0];
			REG_SEG_THR:  thr_r = val;
			REG_QOS_GOOD: good_r = val;
			REG_QOS_FAIR: fair_r = val;
			REG_QOS_POOR: poor_r = val;
			REG_BAD_MEAN: bad_r = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result checking
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", m_tdata);
			end else begin
				logic [7:0] exp_w;
				exp_w = pending_q.pop_front();
				if (m_tdata !== exp_w) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: exp cls %0d qual %0d fid %0d rdy %0d, got cls %0d qual %0d fid %0d rdy %0d",
							exp_w[1:0], exp_w[3:2], exp_w[5:4], exp_w[6],
							m_tdata[1:0], m_tdata[3:2], m_tdata[5:4], m_tdata[6]);
				end
			end
		end
	end

	// output back-pressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(99) < 30) begin
			stall_left <= gap_len();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		word_t dir_tab [$];
		word_t w;
		int i, j, ph, n;
		logic [15:0] cv [6];

		clk = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = 0;
		s_tlast = 0;
		m_tready = 0;
		cfg_we = 0;
		cfg_addr = '0;
		cfg_data = '0;
		mismatches = 0;
		idle_cycles = 0;
		stall_left = 0;
		in_run = 0;
		load_pos = 0;
		best_sum = 0;
		win_done = 0;
		pad_r = 0;
		thr_r = 0;
		good_r = 13107;
		fair_r = 9830;
		poor_r = 6554;
		bad_r = 8192;
		for (i = 0; i < WINDOW_LEN; i++) begin
			cls_mem[i] = 0;
			qual_mem[i] = 0;
			fid_mem[i] = 0;
			mag_mem[i] = 0;
		end

		// directed table
		w = read_word(9'd0);
		w.typed = 1;
		w.want = 8'h00;
		dir_tab.push_back(w);
		w.rpos = 9'd511;
		w.wend = 1;
		dir_tab.push_back(w);
		for (i = 0; i < 12; i++) begin
			w = load_word(0);
			case (i)
				0: w.sc = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
				1: w.sc = '{16'h8000, 16'h7fff, 16'h8000, 16'h8000};
				2: w.sc = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff};
				3: w.sc = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff};
				4: w.sc = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
				5: w.sc = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
				default: w.sc = '{16'h0000, 16'h4000, 16'h0000, 16'h0000};
			endcase
			w.smp = (i == 6) ? 16'h8000 : (i == 8) ? 16'h7fff : 16'($urandom);
			dir_tab.push_back(w);
		end
		w = read_word(9'd5);
		w.typed = 1;
		w.want = 8'h00;
		dir_tab.push_back(w);
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n = 1;
		@(posedge clk);
		foreach (dir_tab[k])
			send(dir_tab[k]);

		// first window fills every position, then a few loads past the end
		while (load_pos < WINDOW_LEN)
			send(load_word(0));
		send(load_word(0));
		send(load_word(0));
		send(load_word(1));
		for (i = 0; i < 60; i++)
			send(read_word(9'($urandom)));

		for (ph = 0; ph < 8; ph++) begin
			wait_drained();
			case (ph)
				0: cv = '{16'd255, 16'h8000, 16'h7fff, 16'h8000, 16'h0000, 16'h8000};
				1: cv = '{16'd0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
				2: cv = '{16'd3, 16'h0000, 16'd13107, 16'd9830, 16'd6554, 16'h8000};
				default: begin
					cv[0] = $urandom_range(9) == 0 ? 16'($urandom_range(255))
						: 16'($urandom_range(20));
					cv[1] = 16'($signed($urandom_range(24000)) - 12000);
					for (j = 2; j < 5; j++)
						cv[j] = 16'($signed($urandom_range(30000)) - 5000);
					cv[5] = 16'($signed($urandom_range(40000)) - 32768);
				end
			endcase
			for (j = 0; j < 6; j++)
				write_reg(reg_idx_t'(j), cv[j]);
			cfg_we <= 1'b0;
			n = (ph == 2) ? WINDOW_LEN : $urandom_range(50, 1);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(19) == 0)
					send(read_word(9'($urandom)));
				send(load_word(i == n - 1));
			end
			for (i = 0; i < 20; i++)
				send(read_word($urandom_range(3) == 0 ? 9'($urandom_range(60))
					: 9'($urandom)));
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
